FILE: rtl/core/krt_pkg.sv
// krt_pkg: sizes, codes, entry layout and divider handshake types
// for the keyed rating table; depends on nothing
`timescale 1ns / 1ps

package krt_pkg;

  // table geometry
  localparam int ENTRIES      = 64;
  localparam int KEY_WIDTH    = 16;
  localparam int RATING_WIDTH = 16;

  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int SUM_W  = RATING_WIDTH + CNT_W;
  localparam int WORD_W = 2 * KEY_WIDTH + RATING_WIDTH;

  // port field widths
  localparam int ACTION_W    = 2;
  localparam int KEY_IN_W    = 16;
  localparam int RATING_IO_W = 16;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_LOOKUP  = 2'd2,
    ACT_AVERAGE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FOUND     = 3'd4,
    ST_AVERAGE   = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]    user;
    logic [KEY_WIDTH-1:0]    item;
    logic [RATING_WIDTH-1:0] rating;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/core/krt_if.sv
// krt_req_if and krt_rsp_if: valid/ready channels for requests and results
// depends on krt_pkg for field widths
`timescale 1ns / 1ps

interface krt_req_if;
  logic                                valid;
  logic                                ready;
  logic [krt_pkg::ACTION_W-1:0]        action;
  logic [krt_pkg::KEY_IN_W-1:0]        user_key;
  logic [krt_pkg::KEY_IN_W-1:0]        item_key;
  logic [krt_pkg::RATING_IO_W-1:0]     rating_in;

  modport source (output valid, action, user_key, item_key, rating_in, input ready);
  modport sink   (input valid, action, user_key, item_key, rating_in, output ready);
endinterface

interface krt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [krt_pkg::STATUS_W-1:0]        status;
  logic [krt_pkg::RATING_IO_W-1:0]     rating_out;
  logic [krt_pkg::COUNT_OUT_W-1:0]     match_count;

  modport source (output valid, status, rating_out, match_count, input ready);
  modport sink   (input valid, status, rating_out, match_count, output ready);
endinterface

FILE: rtl/core/krt_ram.sv
// krt_ram: generic single-write, single-read synchronous ram
// registered read data, valid in the cycle after the read; no dependencies
`timescale 1ns / 1ps

module krt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/krt_div.sv
// krt_div: restoring serial divider, one quotient bit per cycle
// depends on krt_pkg for widths and handshake structs
`timescale 1ns / 1ps

module krt_div (
  input  logic              clk,
  input  logic              rst,
  input  krt_pkg::div_req_t req,
  output krt_pkg::div_rsp_t rsp
);
  import krt_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;

  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo   <= req.dividend;
      rem   <= '0;
      dvs   <= req.divisor;
      steps <= STEP_W'(SUM_W);
    end else if (busy) begin
      if (fits) begin
        rem <= CNT_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[CNT_W-1:0];
      end
      quo   <= {quo[SUM_W-2:0], fits};
      steps <= steps - STEP_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: rtl/core/keyed_rating_table.sv
// keyed_rating_table: top level, request sequencer around the entry ram
// depends on krt_pkg, krt_if, krt_ram and krt_div
`timescale 1ns / 1ps

// channel | role   | payload
// --------+--------+-----------------------------------------------
// req     | sink   | action, user_key, item_key, rating_in
// rsp     | source | status, rating_out, match_count
//
// one request at a time: a scan reads every entry of the ram, one per cycle,
// then the drain, finish and deliver steps follow; an average also runs
// the serial divider between finish and deliver
// reset empties the table at once through the per-entry valid flops
// a stalled result sits in the output register; the next request is taken
// while it waits, and the new result waits for that register to drain

module keyed_rating_table (
  input logic       clk,
  input logic       rst,
  krt_req_if.sink   req,
  krt_rsp_if.source rsp
);
  import krt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_DRAIN   = 6'b000100,
    S_FINISH  = 6'b001000,
    S_DIV     = 6'b010000,
    S_DELIVER = 6'b100000
  } state_t;

  state_t state;

  // captured request
  action_t                 req_action;
  logic [KEY_WIDTH-1:0]    req_user;
  logic [KEY_WIDTH-1:0]    req_item;
  logic [RATING_WIDTH-1:0] req_rating;

  // per-entry valid marks, cleared by reset
  logic [ENTRIES-1:0] valid;

  // scan pointers: read address and the entry whose data is back
  logic [ADDR_W-1:0] scan_idx;
  logic              chk_pending;
  logic [ADDR_W-1:0] chk_idx;

  // scan results
  logic                    hit_found;
  logic [ADDR_W-1:0]       hit_idx;
  logic [RATING_WIDTH-1:0] hit_rating;
  logic                    free_found;
  logic [ADDR_W-1:0]       free_idx;
  logic [SUM_W-1:0]        sum;
  logic [CNT_W-1:0]        count;

  // staged result
  status_t                 res_status;
  logic [RATING_IO_W-1:0]  res_rating;
  logic [COUNT_OUT_W-1:0]  res_count;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [WORD_W-1:0] ram_rdata;
  entry_t            rd_entry;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_xfer;
  logic out_free;
  logic vbit;
  logic pair_hit;
  logic item_hit;

  // no transfer is taken while reset is held
  assign in_xfer  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !rst;
  assign out_free = !rsp.valid || rsp.ready;

  // compare stage on the entry read back last cycle
  assign rd_entry = entry_t'(ram_rdata);
  assign vbit     = valid[chk_idx];
  assign item_hit = vbit && (rd_entry.item == req_item);
  assign pair_hit = item_hit && (rd_entry.user == req_user);

  assign ram_re = (state == S_SCAN);

  // write back happens once, in the finish step, after the scan is over,
  // so a read never overlaps a write to the same entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx;
    ram_wdata = '{user: req_user, item: req_item, rating: req_rating};
    if (state == S_FINISH && req_action == ACT_INSERT) begin
      if (hit_found) begin
        ram_we = 1'b1;
      end else if (free_found) begin
        ram_we    = 1'b1;
        ram_waddr = free_idx;
      end
    end
  end

  // rounded mean: (sum + count/2) / count
  assign div_req.start    = (state == S_FINISH) && (req_action == ACT_AVERAGE)
                            && (count != '0);
  assign div_req.dividend = sum + SUM_W'(count >> 1);
  assign div_req.divisor  = count;

  krt_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  krt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer and valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid       <= '0;
      chk_pending <= 1'b0;
    end else begin
      chk_pending <= (state == S_SCAN);
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_idx == ADDR_W'(ENTRIES - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (req_action == ACT_INSERT && !hit_found && free_found) begin
            valid[free_idx] <= 1'b1;
          end
          if (req_action == ACT_REMOVE && hit_found) begin
            valid[hit_idx] <= 1'b0;
          end
          if (div_req.start) begin
            state <= S_DIV;
          end else begin
            state <= S_DELIVER;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and scan datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_action <= action_t'(req.action);
      req_user   <= KEY_WIDTH'(req.user_key);
      req_item   <= KEY_WIDTH'(req.item_key);
      req_rating <= RATING_WIDTH'(req.rating_in);
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      sum        <= '0;
      count      <= '0;
    end else begin
      if (state == S_SCAN) begin
        scan_idx <= scan_idx + ADDR_W'(1);
      end
      if (chk_pending) begin
        // lowest matching pair and lowest free slot win
        if (pair_hit && !hit_found) begin
          hit_found  <= 1'b1;
          hit_idx    <= chk_idx;
          hit_rating <= rd_entry.rating;
        end
        if (!vbit && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
        if (item_hit) begin
          sum   <= sum + SUM_W'(rd_entry.rating);
          count <= count + CNT_W'(1);
        end
      end
    end
    chk_idx <= scan_idx;
  end

  // result staging
  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      res_rating <= '0;
      res_count  <= '0;
      case (req_action)
        ACT_INSERT: begin
          if (hit_found) begin
            res_status <= ST_UPDATED;
          end else if (free_found) begin
            res_status <= ST_ADDED;
          end else begin
            res_status <= ST_FULL;
          end
        end
        ACT_REMOVE: begin
          res_status <= hit_found ? ST_REMOVED : ST_NOT_FOUND;
        end
        ACT_LOOKUP: begin
          if (hit_found) begin
            res_status <= ST_FOUND;
            res_rating <= RATING_IO_W'(hit_rating);
          end else begin
            res_status <= ST_NOT_FOUND;
          end
        end
        default: begin
          res_status <= ST_AVERAGE;
          res_count  <= COUNT_OUT_W'(count);
        end
      endcase
    end else if (state == S_DIV && div_rsp.done) begin
      res_rating <= RATING_IO_W'(div_rsp.quotient);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DELIVER && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DELIVER && out_free) begin
      rsp.status      <= res_status;
      rsp.rating_out  <= res_rating;
      rsp.match_count <= res_count;
    end
  end

endmodule

FILE: rtl/core/krt_checker.sv
// krt_checker: port-level assertions for keyed_rating_table, plus its bind
// depends on krt_pkg for status codes
`timescale 1ns / 1ps

module krt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [krt_pkg::STATUS_W-1:0]        status,
  input logic [krt_pkg::RATING_IO_W-1:0]     rating_out,
  input logic [krt_pkg::COUNT_OUT_W-1:0]     match_count
);
  import krt_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request in flight: no second transfer right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // only average reports a count
  a_count_avg_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_AVERAGE |-> match_count == '0)
    else $error("match count on a non-average result");

  // table edits and misses carry no rating
  a_rating_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ADDED || status == ST_UPDATED ||
                  status == ST_REMOVED || status == ST_NOT_FOUND ||
                  status == ST_FULL) |-> rating_out == '0)
    else $error("rating on a result that has none");

  // empty average is zero
  a_empty_avg: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_AVERAGE && match_count == '0 |-> rating_out == '0)
    else $error("nonzero average with no matches");

endmodule

bind keyed_rating_table krt_checker u_krt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .status      (rsp.status),
  .rating_out  (rsp.rating_out),
  .match_count (rsp.match_count)
);
